>>> src/vrt_pkg.sv
// Shared types, constants and helper functions for the voxel ray traversal block.
// No dependencies; every other file imports this package.
package vrt_pkg;

  localparam int MAX_VOXELS_DEF    = 63;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CW  = 32;  // coordinate
  localparam int DW  = 33;  // per-axis delta magnitude
  localparam int KW  = 24;  // voxel key
  localparam int RW  = 23;  // config register
  localparam int LW  = 35;  // ray length
  localparam int SQW = 66;  // sum of squares
  localparam int AW  = 3;   // APB address

  // shared multiplier: signed MAW x unsigned MBW, MAW consumed in CHUNK-bit slices
  localparam int MAW    = 54;
  localparam int MBW    = 35;
  localparam int MPW    = 90;
  localparam int CHUNK  = 18;
  localparam int NCHUNK = MAW / CHUNK;

  localparam logic [RW-1:0] VOXEL_SIZE_RST = RW'(6554);
  localparam logic [RW-1:0] INV_SIZE_RST   = RW'(655360);

  localparam logic [3:0] FRONT_LAST_OP = 4'd8;

  localparam logic [4:0] OP_NB = 5'd0;   // boundary * size
  localparam logic [4:0] OP_PM = 5'd3;   // n_i * m_j
  localparam logic [4:0] OP_RR = 5'd9;   // n_i * length
  localparam logic [4:0] OP_MD = 5'd12;  // m_i * length
  localparam logic [4:0] OP_SM = 5'd15;  // size * m_i
  localparam logic [4:0] OP_SD = 5'd18;  // size * length

  localparam logic signed [MPW-1:0] KEY_HI = MPW'(2 ** (KW - 1) - 1);
  localparam logic signed [MPW-1:0] KEY_LO = -KEY_HI - MPW'(1);

  typedef enum logic [0:0] {
    REG_VOXEL_SIZE = 1'b0,
    REG_INV_SIZE   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    F_IDLE, F_ISSUE, F_WAIT, F_ROOT, F_ROOT_WAIT, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ISSUE, B_WAIT, B_CHECK, B_PICK, B_TEST, B_EMIT, B_END
  } back_state_t;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
    logic signed [CW-1:0] target_z;
  } ray_t;

  typedef struct packed {
    logic signed [KW-1:0] cell_x;
    logic signed [KW-1:0] cell_y;
    logic signed [KW-1:0] cell_z;
    logic                 cell_valid;
    logic                 ray_done;
    logic                 truncated;
  } cell_item_t;

  // classified ray handed from front to back
  typedef struct packed {
    logic                 skip;
    logic [2:0]           fin;
    logic [2:0]           neg;
    logic [2:0][CW-1:0]   org;
    logic [2:0][DW-1:0]   mag;
    logic [LW-1:0]        ray_len;
    logic [2:0][KW-1:0]   key;
    logic [2:0][KW-1:0]   key_end;
  } desc_t;

  function automatic logic [KW-1:0] clamp_key(input logic signed [MPW-1:0] v);
    logic [KW-1:0] r;
    if (v > KEY_HI) r = KEY_HI[KW-1:0];
    else if (v < KEY_LO) r = KEY_LO[KW-1:0];
    else r = v[KW-1:0];
    return r;
  endfunction

  // cross-product slots: 0:(0,1) 1:(0,2) 2:(1,0) 3:(1,2) 4:(2,0) 5:(2,1)
  function automatic logic [1:0] pair_row(input logic [2:0] k);
    return 2'(k >> 1);
  endfunction

  function automatic logic [1:0] pair_col(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0: c = 2'd1;
      3'd1: c = 2'd2;
      3'd2: c = 2'd0;
      3'd3: c = 2'd2;
      3'd4: c = 2'd0;
      default: c = 2'd1;
    endcase
    return c;
  endfunction

endpackage

>>> src/vrt_mul.sv
// Sequential signed x unsigned multiplier, one CHUNK-bit slice per cycle.
// Depends on vrt_pkg.
module vrt_mul import vrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [MAW-1:0] a,
  input  logic [MBW-1:0]        b,
  output logic                  done,
  output logic signed [MPW-1:0] p
);

  localparam int ACCW = MAW + MBW;
  localparam int PPW  = CHUNK + MBW;
  localparam int CNTW = $clog2(NCHUNK + 1);

  logic [MAW-1:0]        mag_r;
  logic                  neg_r;
  logic [MBW-1:0]        b_r;
  logic [ACCW-1:0]       acc_r;
  logic [CNTW-1:0]       cnt_r;
  logic                  busy_r, fin_r, done_r;
  logic signed [MPW-1:0] p_r;
  logic [PPW-1:0]        pp;

  assign pp = mag_r[MAW-1 -: CHUNK] * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NCHUNK);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // top slice first, so every shift is fixed
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= a[MAW-1] ? MAW'(-a) : MAW'(a);
      neg_r <= a[MAW-1];
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << CHUNK) + ACCW'(pp);
      mag_r <= mag_r << CHUNK;
    end
    if (fin_r) begin
      p_r <= neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

>>> src/vrt_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on vrt_pkg.
module vrt_sqrt import vrt_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [SQW-1:0] rad,
  output logic           done,
  output logic [LW-1:0]  root
);

  localparam int NP   = SQW / 2;
  localparam int RMW  = NP + 4;
  localparam int CNTW = $clog2(NP + 1);

  logic [SQW-1:0]  rad_r;
  logic [RMW-1:0]  rem_r, rem_sh, trial;
  logic [NP-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r, ge;

  always_comb begin
    rem_sh = {rem_r[RMW-3:0], rad_r[SQW-1 -: 2]};
    trial  = {{(RMW-NP-2){1'b0}}, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NP);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[NP-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = LW'(root_r);

endmodule

>>> src/vrt_fifo.sv
// Short queue of classified rays between the front and back parts.
// Depends on vrt_pkg for the descriptor type.
module vrt_fifo import vrt_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t pop_desc,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  desc_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [FW-1:0]  fill_r;

  assign full     = fill_r == FW'(DEPTH);
  assign empty    = fill_r == '0;
  assign pop_desc = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop) fill_r <= fill_r + FW'(1);
      else if (pop && !push) fill_r <= fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_desc;
  end

endmodule

>>> src/vrt_front.sv
// Front part: takes a ray, forms deltas, length and voxel keys, classifies it and queues it.
// Depends on vrt_pkg, vrt_mul and vrt_sqrt.
module vrt_front import vrt_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ray_t          in_data,
  input  logic [RW-1:0] voxel_size,
  input  logic [RW-1:0] inv_size,
  output logic          push,
  output desc_t         push_desc,
  input  logic          q_full
);

  front_state_t state_r, state_nxt;

  logic [2:0][CW-1:0] org_r, tgt_r, in_org, in_tgt;
  logic [2:0][DW-1:0] mag_r;
  logic [2:0]         neg_r, fin_r;
  logic [SQW-1:0]     sum_r;
  logic [3:0]         op_r;
  logic [5:0][KW-1:0] key_r;
  logic [LW-1:0]      len_r;
  logic signed [DW-1:0] d [3];

  logic                  mul_start, mul_done;
  logic signed [MAW-1:0] mul_a;
  logic [MBW-1:0]        mul_b;
  logic signed [MPW-1:0] mul_p, kshift;
  logic                  sq_start, sq_done;
  logic [LW-1:0]         sq_root;
  logic [2:0]            kidx;
  logic [CW-1:0]         coord;

  vrt_mul u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  vrt_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .rad(sum_r), .done(sq_done), .root(sq_root)
  );

  always_comb begin
    in_org = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
    in_tgt = {in_data.target_z, in_data.target_y, in_data.target_x};
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({in_tgt[i][CW-1], in_tgt[i]}) - $signed({in_org[i][CW-1], in_org[i]});
    end
  end

  // operand select: squares first, then the six keys
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    kidx  = 3'(op_r - 4'd3);
    coord = (kidx < 3'd3) ? org_r[kidx[1:0]] : tgt_r[2'(kidx - 3'd3)];
    if (op_r < 4'd3) begin
      mul_a = $signed({{(MAW-DW){1'b0}}, mag_r[op_r[1:0]]});
      mul_b = {{(MBW-DW){1'b0}}, mag_r[op_r[1:0]]};
    end else begin
      mul_a = $signed({{(MAW-CW){coord[CW-1]}}, coord});
      mul_b = MBW'(inv_size);
    end
  end

  assign kshift = mul_p >>> (2 * FRACTION_BITS);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:      if (in_valid) state_nxt = F_ISSUE;
      F_ISSUE:     state_nxt = F_WAIT;
      F_WAIT:      if (mul_done) state_nxt = (op_r == FRONT_LAST_OP) ? F_ROOT : F_ISSUE;
      F_ROOT:      state_nxt = F_ROOT_WAIT;
      F_ROOT_WAIT: if (sq_done) state_nxt = F_PUSH;
      F_PUSH:      if (!q_full) state_nxt = F_IDLE;
      default:     state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state_r == F_IDLE;
    mul_start = state_r == F_ISSUE;
    sq_start  = state_r == F_ROOT;
    push      = (state_r == F_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      org_r <= in_org;
      tgt_r <= in_tgt;
      sum_r <= '0;
      op_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
        neg_r[i] <= d[i][DW-1];
        fin_r[i] <= d[i] != '0;
      end
    end
    if (state_r == F_WAIT && mul_done) begin
      op_r <= op_r + 4'd1;
      if (op_r < 4'd3) sum_r <= sum_r + mul_p[SQW-1:0];
      else             key_r[kidx] <= clamp_key(kshift);
    end
    if (sq_done) len_r <= sq_root;
  end

  always_comb begin
    push_desc.skip    = (len_r == '0) || ({len_r, 1'b0} < (LW+1)'(voxel_size));
    push_desc.fin     = fin_r;
    push_desc.neg     = neg_r;
    push_desc.org     = org_r;
    push_desc.mag     = mag_r;
    push_desc.ray_len = len_r;
    push_desc.key     = {key_r[2], key_r[1], key_r[0]};
    push_desc.key_end = {key_r[5], key_r[4], key_r[3]};
  end

endmodule

>>> src/vrt_back.sv
// Back part: sets up exact crossing products for a queued ray, then steps voxel by voxel.
// Depends on vrt_pkg and vrt_mul.
module vrt_back import vrt_pkg::*; #(
  parameter int MAX_VOXELS = MAX_VOXELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [RW-1:0] voxel_size,
  input  logic          q_empty,
  input  desc_t         q_desc,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output cell_item_t    out_data
);

  localparam int CNTW = $clog2(MAX_VOXELS + 1);

  back_state_t state_r, state_nxt;

  desc_t                 d_r;
  logic [2:0][KW-1:0]    v_r, vn;
  logic signed [MAW-1:0] n_r  [3];
  logic signed [MPW-1:0] pm_r [6];
  logic signed [MPW-1:0] rr_r [3];
  logic signed [MPW-1:0] md_r [3];
  logic signed [MPW-1:0] sm_r [3];
  logic signed [MPW-1:0] sd_r;
  logic [4:0]            op_r;
  logic [1:0]            axis_r, ai, nxt_axis;
  logic [2:0]            pk;
  logic [CNTW-1:0]       cnt_r;
  logic                  trunc_r;
  logic                  out_valid_r;
  cell_item_t            out_data_r;

  logic                  mul_start, mul_done;
  logic signed [MAW-1:0] mul_a;
  logic [MBW-1:0]        mul_b;
  logic signed [MPW-1:0] mul_p, org_w, diff;
  logic [KW:0]           bk, vsum;
  logic                  pos, lt01, lt02, lt12, stop_dist, reach, at_max, out_free;
  logic                  load_cell, load_end;

  vrt_mul u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  // setup operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ai    = '0;
    pk    = 3'(op_r - OP_PM);
    bk    = '0;
    pos   = 1'b0;
    case (op_r) inside
      [OP_NB:OP_NB+5'd2]: begin
        ai    = 2'(op_r - OP_NB);
        pos   = d_r.fin[ai] && !d_r.neg[ai];
        bk    = {v_r[ai][KW-1], v_r[ai]} + (pos ? (KW+1)'(1) : '0);
        mul_a = $signed({{(MAW-KW-1){bk[KW]}}, bk});
        mul_b = MBW'(voxel_size);
      end
      [OP_PM:OP_PM+5'd5]: begin
        mul_a = n_r[pair_row(pk)];
        mul_b = MBW'(d_r.mag[pair_col(pk)]);
      end
      [OP_RR:OP_RR+5'd2]: begin
        ai    = 2'(op_r - OP_RR);
        mul_a = n_r[ai];
        mul_b = d_r.ray_len;
      end
      [OP_MD:OP_MD+5'd2]: begin
        ai    = 2'(op_r - OP_MD);
        mul_a = $signed(MAW'(d_r.mag[ai]));
        mul_b = d_r.ray_len;
      end
      [OP_SM:OP_SM+5'd2]: begin
        ai    = 2'(op_r - OP_SM);
        mul_a = $signed(MAW'(voxel_size));
        mul_b = MBW'(d_r.mag[ai]);
      end
      default: begin
        mul_a = $signed(MAW'(voxel_size));
        mul_b = d_r.ray_len;
      end
    endcase
  end

  assign org_w = $signed({{(MPW-CW){d_r.org[ai][CW-1]}}, d_r.org[ai]});

  // earliest crossing; on ties the later axis wins
  always_comb begin
    lt01 = d_r.fin[0] && (!d_r.fin[1] || pm_r[0] < pm_r[2]);
    lt02 = d_r.fin[0] && (!d_r.fin[2] || pm_r[1] < pm_r[4]);
    lt12 = d_r.fin[1] && (!d_r.fin[2] || pm_r[3] < pm_r[5]);
    if (lt01) nxt_axis = lt02 ? 2'd0 : 2'd2;
    else      nxt_axis = lt12 ? 2'd1 : 2'd2;
  end

  // stop when (m - n) * length < size * m
  always_comb begin
    diff      = md_r[axis_r] - rr_r[axis_r];
    stop_dist = diff < sm_r[axis_r];
    vsum      = {v_r[axis_r][KW-1], v_r[axis_r]};
    if (d_r.fin[axis_r]) vsum = d_r.neg[axis_r] ? vsum - (KW+1)'(1) : vsum + (KW+1)'(1);
    vn         = v_r;
    vn[axis_r] = clamp_key($signed({{(MPW-KW-1){vsum[KW]}}, vsum}));
    reach      = vn == d_r.key_end;
    at_max     = cnt_r >= CNTW'(MAX_VOXELS);
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = q_desc.skip ? B_END : B_ISSUE;
      B_ISSUE: state_nxt = B_WAIT;
      B_WAIT:  if (mul_done) state_nxt = (op_r == OP_SD) ? B_CHECK : B_ISSUE;
      B_CHECK: state_nxt = (v_r == d_r.key_end) ? B_END : B_PICK;
      B_PICK:  state_nxt = B_TEST;
      B_TEST:  state_nxt = (stop_dist || reach || at_max) ? B_END : B_EMIT;
      B_EMIT:  if (out_free) state_nxt = B_PICK;
      B_END:   if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state_r == B_IDLE) && !q_empty;
    mul_start = state_r == B_ISSUE;
    load_cell = (state_r == B_EMIT) && out_free;
    load_end  = (state_r == B_END) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      trunc_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      if (load_cell || load_end) out_valid_r <= 1'b1;
      if (pop) begin
        trunc_r <= 1'b0;
        cnt_r   <= '0;
      end
      if (state_r == B_TEST && !stop_dist && !reach && at_max) trunc_r <= 1'b1;
      if (load_cell) cnt_r <= cnt_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      d_r  <= q_desc;
      v_r  <= q_desc.key;
      op_r <= '0;
    end
    if (state_r == B_WAIT && mul_done) begin
      op_r <= op_r + 5'd1;
      case (op_r) inside
        [OP_NB:OP_NB+5'd2]: begin
          if (!d_r.fin[ai])      n_r[ai] <= '0;
          else if (pos)          n_r[ai] <= MAW'(mul_p - org_w);
          else                   n_r[ai] <= MAW'(org_w - mul_p);
        end
        [OP_PM:OP_PM+5'd5]: pm_r[pk] <= mul_p;
        [OP_RR:OP_RR+5'd2]: rr_r[ai] <= mul_p;
        [OP_MD:OP_MD+5'd2]: md_r[ai] <= mul_p;
        [OP_SM:OP_SM+5'd2]: sm_r[ai] <= mul_p;
        default:            sd_r     <= mul_p;
      endcase
    end
    if (state_r == B_PICK) axis_r <= nxt_axis;
    if (state_r == B_TEST && !stop_dist) begin
      for (int k = 0; k < 6; k++) begin
        if (pair_row(3'(k)) == axis_r) pm_r[k] <= pm_r[k] + sm_r[pair_col(3'(k))];
      end
      rr_r[axis_r] <= rr_r[axis_r] + sd_r;
      v_r          <= vn;
    end
    if (load_cell) begin
      out_data_r.cell_x     <= $signed(v_r[0]);
      out_data_r.cell_y     <= $signed(v_r[1]);
      out_data_r.cell_z     <= $signed(v_r[2]);
      out_data_r.cell_valid <= 1'b1;
      out_data_r.ray_done   <= 1'b0;
      out_data_r.truncated  <= 1'b0;
    end else if (load_end) begin
      out_data_r.cell_x     <= '0;
      out_data_r.cell_y     <= '0;
      out_data_r.cell_z     <= '0;
      out_data_r.cell_valid <= 1'b0;
      out_data_r.ray_done   <= 1'b1;
      out_data_r.truncated  <= trunc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/voxel_ray_traversal_3d.sv
// Front: nine multiplies and a square root per ray. Back: a setup of nineteen multiplies on
// one shared multiplier before the first voxel, then the pick, test and emit states for each
// voxel, stalling in emit while the output is not taken. While one ray occupies the back, the
// front classifies the next ray.
// Reset: synchronous, active low; control state cleared and registers to their defaults.
// Depends on vrt_pkg, vrt_front, vrt_fifo and vrt_back.
module voxel_ray_traversal_3d import vrt_pkg::*; #(
  parameter int MAX_VOXELS    = MAX_VOXELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ray_t          in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cell_item_t    out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [RW-1:0] voxel_size_r, inv_size_r;
  logic          q_push, q_pop, q_full, q_empty;
  desc_t         q_in, q_out;
  reg_idx_t      ridx;

  assign ridx   = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voxel_size_r <= VOXEL_SIZE_RST;
      inv_size_r   <= INV_SIZE_RST;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_VOXEL_SIZE: voxel_size_r <= pwdata[RW-1:0];
        REG_INV_SIZE:   inv_size_r   <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_VOXEL_SIZE: prdata = 32'(voxel_size_r);
      REG_INV_SIZE:   prdata = 32'(inv_size_r);
      default:        prdata = '0;
    endcase
  end

  vrt_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .voxel_size(voxel_size_r), .inv_size(inv_size_r),
    .push(q_push), .push_desc(q_in), .q_full
  );

  vrt_fifo #(.DEPTH(2)) u_fifo (
    .clk, .rst_n, .push(q_push), .push_desc(q_in), .full(q_full),
    .pop(q_pop), .pop_desc(q_out), .empty(q_empty)
  );

  vrt_back #(.MAX_VOXELS(MAX_VOXELS)) u_back (
    .clk, .rst_n, .voxel_size(voxel_size_r), .q_empty, .q_desc(q_out), .pop(q_pop),
    .out_valid, .out_ready, .out_data
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full && !q_pop))
    else $error("ray queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("ray queue underflow");

  a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cell_valid |->
      out_data.ray_done && out_data.cell_x == '0 && out_data.cell_y == '0 &&
      out_data.cell_z == '0)
    else $error("malformed end item");

  a_cell_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cell_valid |-> !out_data.ray_done && !out_data.truncated)
    else $error("voxel item flagged as end");

endmodule

>>> dv/tb_top.sv
// Self-checking bench for voxel_ray_traversal_3d: rays in, traversed voxel keys out.
// Predicts every item with its own fixed-point traversal; depends on vrt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import vrt_pkg::*;

  localparam int  HOLD_CYCLES = 3000;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  NPHASE      = 7;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  ray_t          in_data;
  logic          out_valid;
  logic          out_ready;
  cell_item_t    out_data;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  voxel_ray_traversal_3d dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ray_t       ray_q[$];
  cell_item_t cell_q[$];
  int         errors;
  int         cycles;
  int         send_idle;
  int         recv_stall;
  bit         hold_req;
  int         hold_left;

  // local copy of the two registers
  logic [RW-1:0] edge_len;
  logic [RW-1:0] inv_len;

  // traversal scratch
  logic signed [63:0] cross_n[3];
  logic signed [63:0] span[3];
  bit                 moving[3];

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  function automatic logic signed [127:0] wmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [127:0] x;
    logic signed [127:0] y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic logic signed [63:0] sat_key(input logic signed [63:0] k);
    logic signed [63:0] r;
    r = k;
    if (k > 64'sd8388607) r = 64'sd8388607;
    if (k < -64'sd8388608) r = -64'sd8388608;
    return r;
  endfunction

  function automatic logic signed [63:0] cell_key(input logic signed [63:0] c);
    logic signed [63:0] p;
    logic signed [63:0] inv;
    inv = {41'd0, inv_len};
    p = c * inv;
    return sat_key(p >>> 32);
  endfunction

  // axis i crosses its next boundary strictly earlier than axis j
  function automatic bit earlier(input int i, input int j);
    if (!moving[i]) return 1'b0;
    if (!moving[j]) return 1'b1;
    return wmul(cross_n[i], span[j]) < wmul(cross_n[j], span[i]);
  endfunction

  task automatic predict_cells(input ray_t r);
    logic signed [63:0] org[3];
    logic signed [63:0] tgt[3];
    logic signed [63:0] d;
    logic signed [63:0] key[3];
    logic signed [63:0] kend[3];
    logic signed [63:0] s;
    logic signed [63:0] q;
    logic signed [63:0] ray_len;
    logic [127:0]       sumsq;
    logic [127:0]       c;
    int                 step[3];
    int                 ax;
    int                 cnt;
    bit                 trunc;
    cell_item_t         it;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    tgt = '{r.target_x, r.target_y, r.target_z};
    s = {41'd0, edge_len};
    sumsq = '0;
    cnt = 0;
    trunc = 1'b0;
    for (int a = 0; a < 3; a++) begin
      d = tgt[a] - org[a];
      span[a] = d < 0 ? -d : d;
      step[a] = d > 0 ? 1 : (d < 0 ? -1 : 0);
      sumsq += 128'(span[a]) * 128'(span[a]);
    end
    ray_len = 0;
    for (int b = 34; b >= 0; b--) begin
      c = 128'(ray_len) | (128'd1 << b);
      if (c * c <= sumsq) ray_len = 64'(c);
    end
    if (ray_len != 0 && 2 * ray_len >= s) begin
      for (int a = 0; a < 3; a++) begin
        key[a] = cell_key(org[a]);
        kend[a] = cell_key(tgt[a]);
        moving[a] = step[a] != 0;
        cross_n[a] = 0;
        if (moving[a])
          cross_n[a] = (((step[a] > 0) ? key[a] + 1 : key[a]) * s - org[a]) * step[a];
      end
      while (key[0] != kend[0] || key[1] != kend[1] || key[2] != kend[2]) begin
        // ties go to y/z over x, z over y
        if (earlier(0, 1)) ax = earlier(0, 2) ? 0 : 2;
        else ax = earlier(1, 2) ? 1 : 2;
        q = span[ax] - cross_n[ax];
        key[ax] = sat_key(key[ax] + step[ax]);
        if (wmul(q, ray_len) < wmul(s, span[ax])) break;
        cross_n[ax] += s;
        if (key[0] == kend[0] && key[1] == kend[1] && key[2] == kend[2]) break;
        if (cnt >= MAX_VOXELS_DEF) begin
          trunc = 1'b1;
          break;
        end
        it = '{key[0][KW-1:0], key[1][KW-1:0], key[2][KW-1:0], 1'b1, 1'b0, 1'b0};
        cell_q.insert(cell_q.size(), it);
        cnt++;
      end
    end
    it = '{'0, '0, '0, 1'b0, 1'b1, trunc};
    cell_q.insert(cell_q.size(), it);
  endtask

  task automatic push_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                          input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] tz);
    ray_t r;
    r = '{ox, oy, oz, tx, ty, tz};
    ray_q.insert(ray_q.size(), r);
  endtask

  function automatic logic [31:0] rand_delta();
    logic signed [63:0] lim;
    logic signed [63:0] v;
    lim = 64'(edge_len) * $urandom_range(1, 20);
    case ($urandom_range(5))
      0: v = 0;
      1: v = $signed(64'($urandom_range(4)));
      default: v = $signed(64'($urandom_range(32'(2 * lim)))) - lim;
    endcase
    return v[31:0];
  endfunction

  task automatic add_random(input int count);
    logic [31:0] o[3];
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 2) begin
        push_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        for (int a = 0; a < 3; a++)
          o[a] = $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(2097152)) - 1048576);
        push_ray(o[0], o[1], o[2],
                 o[0] + rand_delta(), o[1] + rand_delta(), o[2] + rand_delta());
      end
    end
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [RW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(4 * int'(idx));
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_VOXEL_SIZE) edge_len = val;
    else inv_len = val;
  endtask

  // checked away from the rising edge so that queue and valid updates have settled
  task automatic drain();
    @(negedge clk);
    while (ray_q.size() != 0 || in_valid || cell_q.size() != 0) @(negedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // sender: prediction happens as each ray is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_cells(in_data);
      if (ray_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data  <= ray_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    cell_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cell_q.size() == 0) begin
        report("unexpected item", 32'(out_data.cell_x), 32'(out_data.ray_done));
      end else begin
        want = cell_q.pop_front();
        if (out_data.cell_x !== want.cell_x) report("cell_x", 32'(out_data.cell_x), 32'(want.cell_x));
        if (out_data.cell_y !== want.cell_y) report("cell_y", 32'(out_data.cell_y), 32'(want.cell_y));
        if (out_data.cell_z !== want.cell_z) report("cell_z", 32'(out_data.cell_z), 32'(want.cell_z));
        if (out_data.cell_valid !== want.cell_valid)
          report("cell_valid", 32'(out_data.cell_valid), 32'(want.cell_valid));
        if (out_data.ray_done !== want.ray_done)
          report("ray_done", 32'(out_data.ray_done), 32'(want.ray_done));
        if (out_data.truncated !== want.truncated)
          report("truncated", 32'(out_data.truncated), 32'(want.truncated));
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_stall;
    end
  end

  initial begin
    int vs_set[NPHASE]   = '{6554, 655, 6553600, 65536, 6554, 655, 6553600};
    int inv_set[NPHASE]  = '{655360, 6553600, 655, 65536, 65536, 655, 6553600};
    int sidle[NPHASE]    = '{0, 51, 0, 13, 0, 13, 51};
    int rstall[NPHASE]   = '{0, 0, 51, 13, 0, 13, 0};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b0;
    hold_left = 0;
    edge_len = VOXEL_SIZE_RST;
    inv_len = INV_SIZE_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed rays on reset settings (0.1 m voxels)
    push_ray(0, 0, 0, 0, 0, 0);                                  // zero length
    push_ray(0, 0, 0, 100, 0, 0);                                // shorter than half a voxel
    push_ray(1000, 1000, 1000, 5000, 1000, 1000);                // same voxel
    push_ray(0, 0, 0, 10 * 65536, 0, 0);
    push_ray(0, 65536, 0, 0, -65536, 0);
    push_ray(0, 0, -65536, 0, 0, 65536);
    push_ray(0, 0, 0, 65536, 65536, 65536);                      // exact ties
    push_ray(-3 * 65536, 2 * 65536, -65536, 3 * 65536, -2 * 65536, 65536);
    push_ray(0, 0, 0, 32'h7fffffff, 0, 0);                       // truncated
    push_ray(32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000);
    push_ray(32'hffffffff, 0, 32'hffffffff, 6554, 6554, 6554);
    push_ray(6553, 6554, 6555, 6553, 6554, 6555 + 3 * 6554);

    for (int p = 0; p < NPHASE; p++) begin
      drain();
      reg_write(REG_VOXEL_SIZE, RW'(vs_set[p]));
      reg_write(REG_INV_SIZE, RW'(inv_set[p]));
      send_idle  = sidle[p];
      recv_stall = rstall[p];
      if (p == 3) hold_req = 1'b1;   // long receiver hold, sender keeps offering
      add_random(p == 0 ? 28 : 40);
    end
    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
